// ===== sv/ffra_pkg.sv =====
// ffra_pkg: shared types and constants for the first-fit range allocator.
// Used by ffra_seq and first_fit_range_allocator_core; no dependencies.
`default_nettype none

package ffra_pkg;

  // Field widths fixed by the command and result formats
  localparam int CAP_W  = 9;
  localparam int SIZE_W = 9;
  localparam int IDX_W  = 8;
  localparam int CNT_W  = 9;

  localparam int              MEM_UNITS_DEF = 256;
  localparam logic [CAP_W-1:0] CAP_RESET    = 9'd256;

  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    STAT_DONE    = 2'd0,
    STAT_NOFIT   = 2'd1,
    STAT_BADSIZE = 2'd2,
    STAT_UNKNOWN = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_SCAN,
    S_MARK,
    S_FREE_RD,
    S_FREE_CHK,
    S_UNMARK,
    S_REPLY
  } state_t;

  // Command beat
  typedef struct packed {
    cmd_t              command;
    logic [SIZE_W-1:0] request_size;
    logic [IDX_W-1:0]  block_start;
  } in_beat_t;

  // Result beat
  typedef struct packed {
    status_t          status;
    logic [IDX_W-1:0] start_index;
    logic [CNT_W-1:0] allocated_total;
    logic [CNT_W-1:0] free_total;
    logic [CNT_W-1:0] block_count;
  } out_beat_t;

  // One word of the unit table: used bit, block head bit, block length
  typedef struct packed {
    logic              used;
    logic              head;
    logic [SIZE_W-1:0] len;
  } mem_word_t;

endpackage

`default_nettype wire

// ===== sv/ffra_ram.sv =====
// ffra_ram: generic single-write, single-read RAM with registered read data.
// No package dependencies.
`default_nettype none

module ffra_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== sv/ffra_seq.sv =====
// ffra_seq: command sequencer with the shared run counter/compare unit.
// Drives the unit table RAM; depends on ffra_pkg.
`default_nettype none

module ffra_seq #(
  parameter int MEM_UNITS = ffra_pkg::MEM_UNITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  input  wire ffra_pkg::in_beat_t            in_beat,
  output logic                               busy,
  output logic                               out_valid,
  output ffra_pkg::out_beat_t                out_beat,
  input  wire logic [ffra_pkg::CAP_W-1:0]    eff_cap,
  output logic                               ram_we,
  output logic [$clog2(MEM_UNITS)-1:0]       ram_waddr,
  output ffra_pkg::mem_word_t                ram_wdata,
  output logic [$clog2(MEM_UNITS)-1:0]       ram_raddr,
  input  wire ffra_pkg::mem_word_t           ram_rdata
);

  localparam int AW = $clog2(MEM_UNITS);
  localparam int SW = ffra_pkg::SIZE_W;
  localparam int CW = ffra_pkg::CNT_W;

  ffra_pkg::state_t  state_r, state_nxt;
  ffra_pkg::status_t status_r, status_nxt;
  logic [SW-1:0]     size_r, size_nxt;
  logic [ffra_pkg::IDX_W-1:0] bstart_r, bstart_nxt;
  logic [SW-1:0]     iss_r, iss_nxt;     // next unit to read
  logic [SW-1:0]     chk_r, chk_nxt;     // unit whose data is on ram_rdata
  logic              rv_r, rv_nxt;       // ram_rdata holds a scan read
  logic [SW-1:0]     run_r, run_nxt;
  logic [SW-1:0]     wr_r, wr_nxt;
  logic [SW-1:0]     cnt_r, cnt_nxt;
  logic [SW-1:0]     grant_r, grant_nxt;
  logic [AW-1:0]     clr_r, clr_nxt;
  logic [CW-1:0]     alloc_r, alloc_nxt;
  logic [CW-1:0]     live_r, live_nxt;
  logic              out_valid_r, out_valid_nxt;
  ffra_pkg::out_beat_t out_beat_r, out_beat_nxt;

  logic [SW-1:0] run_inc;
  logic [SW-1:0] len_rd;

  assign busy      = (state_r != ffra_pkg::S_IDLE);
  assign out_valid = out_valid_r;
  assign out_beat  = out_beat_r;

  // state and datapath registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ffra_pkg::S_INIT;
      clr_r       <= '0;
      alloc_r     <= '0;
      live_r      <= '0;
      rv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      alloc_r     <= alloc_nxt;
      live_r      <= live_nxt;
      rv_r        <= rv_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    status_r   <= status_nxt;
    size_r     <= size_nxt;
    bstart_r   <= bstart_nxt;
    iss_r      <= iss_nxt;
    chk_r      <= chk_nxt;
    run_r      <= run_nxt;
    wr_r       <= wr_nxt;
    cnt_r      <= cnt_nxt;
    grant_r    <= grant_nxt;
    out_beat_r <= out_beat_nxt;
  end

  // shared run unit: extend or restart the free run
  assign run_inc = ram_rdata.used ? '0 : run_r + SW'(1);
  assign len_rd  = ram_rdata.len;

  // next state and outputs
  always_comb begin
    state_nxt     = state_r;
    status_nxt    = status_r;
    size_nxt      = size_r;
    bstart_nxt    = bstart_r;
    iss_nxt       = iss_r;
    chk_nxt       = chk_r;
    rv_nxt        = 1'b0;
    run_nxt       = run_r;
    wr_nxt        = wr_r;
    cnt_nxt       = cnt_r;
    grant_nxt     = grant_r;
    clr_nxt       = clr_r;
    alloc_nxt     = alloc_r;
    live_nxt      = live_r;
    out_valid_nxt = 1'b0;
    out_beat_nxt  = out_beat_r;
    ram_we        = 1'b0;
    ram_waddr     = AW'(wr_r);
    ram_wdata     = '0;
    ram_raddr     = AW'(iss_r);

    unique case (state_r)
      // clearing pass over the unit table after reset
      ffra_pkg::S_INIT: begin
        ram_we    = 1'b1;
        ram_waddr = clr_r;
        clr_nxt   = clr_r + AW'(1);
        if (clr_r == AW'(MEM_UNITS - 1)) begin
          state_nxt = ffra_pkg::S_IDLE;
        end
      end

      ffra_pkg::S_IDLE: begin
        if (start) begin
          size_nxt   = in_beat.request_size;
          bstart_nxt = in_beat.block_start;
          grant_nxt  = '0;
          status_nxt = ffra_pkg::STAT_DONE;
          if (in_beat.command == ffra_pkg::CMD_ALLOC) begin
            if (in_beat.request_size == '0 || in_beat.request_size > eff_cap) begin
              status_nxt = ffra_pkg::STAT_BADSIZE;
              state_nxt  = ffra_pkg::S_REPLY;
            end else begin
              iss_nxt   = '0;
              run_nxt   = '0;
              state_nxt = ffra_pkg::S_SCAN;
            end
          end else if (32'(in_beat.block_start) >= MEM_UNITS) begin
            status_nxt = ffra_pkg::STAT_UNKNOWN;
            state_nxt  = ffra_pkg::S_REPLY;
          end else begin
            state_nxt = ffra_pkg::S_FREE_RD;
          end
        end
      end

      // one unit read issued and one unit checked per cycle
      ffra_pkg::S_SCAN: begin
        if (iss_r < eff_cap) begin
          iss_nxt = iss_r + SW'(1);
          rv_nxt  = 1'b1;
        end
        chk_nxt = iss_r;
        if (rv_r) begin
          run_nxt = run_inc;
          if (run_inc == size_r) begin
            grant_nxt = chk_r + SW'(1) - size_r;
            wr_nxt    = chk_r + SW'(1) - size_r;
            cnt_nxt   = size_r;
            alloc_nxt = alloc_r + CW'(size_r);
            live_nxt  = live_r + CW'(1);
            rv_nxt    = 1'b0;
            state_nxt = ffra_pkg::S_MARK;
          end else if (chk_r == eff_cap - SW'(1)) begin
            status_nxt = ffra_pkg::STAT_NOFIT;
            rv_nxt     = 1'b0;
            state_nxt  = ffra_pkg::S_REPLY;
          end
        end
      end

      // mark the granted run, head on its first unit
      ffra_pkg::S_MARK: begin
        ram_we         = 1'b1;
        ram_wdata.used = 1'b1;
        ram_wdata.head = (wr_r == grant_r);
        ram_wdata.len  = size_r;
        wr_nxt         = wr_r + SW'(1);
        cnt_nxt        = cnt_r - SW'(1);
        if (cnt_r == SW'(1)) begin
          state_nxt = ffra_pkg::S_REPLY;
        end
      end

      ffra_pkg::S_FREE_RD: begin
        ram_raddr = AW'(bstart_r);
        state_nxt = ffra_pkg::S_FREE_CHK;
      end

      ffra_pkg::S_FREE_CHK: begin
        ram_raddr = AW'(bstart_r);
        if (!ram_rdata.head) begin
          status_nxt = ffra_pkg::STAT_UNKNOWN;
          state_nxt  = ffra_pkg::S_REPLY;
        end else begin
          alloc_nxt = (alloc_r >= CW'(len_rd)) ? alloc_r - CW'(len_rd) : '0;
          live_nxt  = (live_r != '0) ? live_r - CW'(1) : '0;
          wr_nxt    = SW'(bstart_r);
          cnt_nxt   = len_rd;
          state_nxt = (len_rd == '0) ? ffra_pkg::S_REPLY : ffra_pkg::S_UNMARK;
        end
      end

      // release the run; clears the head bit too
      ffra_pkg::S_UNMARK: begin
        ram_we  = 1'b1;
        wr_nxt  = wr_r + SW'(1);
        cnt_nxt = cnt_r - SW'(1);
        if (cnt_r == SW'(1)) begin
          state_nxt = ffra_pkg::S_REPLY;
        end
      end

      ffra_pkg::S_REPLY: begin
        out_valid_nxt                = 1'b1;
        out_beat_nxt.status          = status_r;
        out_beat_nxt.start_index     = grant_r[ffra_pkg::IDX_W-1:0];
        out_beat_nxt.allocated_total = alloc_r;
        out_beat_nxt.free_total      = (CW'(eff_cap) >= alloc_r) ?
                                       CW'(eff_cap) - alloc_r : '0;
        out_beat_nxt.block_count     = live_r;
        state_nxt                    = ffra_pkg::S_IDLE;
      end

      default: begin
        state_nxt = ffra_pkg::S_IDLE;
      end
    endcase
  end

  // checks
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |=> !out_valid_r)
    else $error("result strobe held for more than one cycle");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("command accepted but sequencer not busy");

  a_write_states: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == ffra_pkg::S_INIT || state_r == ffra_pkg::S_MARK ||
                state_r == ffra_pkg::S_UNMARK))
    else $error("table write outside a write phase");

  a_reply_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (state_r == ffra_pkg::S_IDLE))
    else $error("result shown while sequencer busy");

  a_no_grant: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_beat_r.status != ffra_pkg::STAT_DONE) |->
      (out_beat_r.start_index == '0))
    else $error("failed command reports a start index");

endmodule

`default_nettype wire

// ===== sv/first_fit_range_allocator_core.sv =====
// first_fit_range_allocator_core: top level, capacity register, unit table.
// Depends on ffra_pkg, ffra_ram and ffra_seq.
//
// Usage:
//   A command beat (in_beat) is taken at a clock edge where start is high
//   and busy is low. Allocate scans the unit table from unit 0 for the
//   first free run of request_size units; free releases the block whose
//   head is at block_start. Each command gives one result beat on
//   out_beat, marked by out_valid for exactly one cycle; the receiver
//   cannot hold it off.
//   The table gives one unit per cycle, and busy stays high throughout a
//   command; the next command can be taken at the edge that takes the
//   result.
//   cfg_we / cfg_wdata write the capacity register, to be used while idle.
//   After reset busy is high for a clearing pass over the unit table; then
//   no blocks are live and the capacity is 256.
`default_nettype none

module first_fit_range_allocator_core #(
  parameter int MEM_UNITS = ffra_pkg::MEM_UNITS_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  output logic                            busy,
  input  wire ffra_pkg::in_beat_t         in_beat,
  output logic                            out_valid,
  output ffra_pkg::out_beat_t             out_beat,
  input  wire logic                       cfg_we,
  input  wire logic [ffra_pkg::CAP_W-1:0] cfg_wdata
);

  localparam int AW = $clog2(MEM_UNITS);

  logic [ffra_pkg::CAP_W-1:0] cap_r;
  logic [ffra_pkg::CAP_W-1:0] eff_cap;

  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  logic [AW-1:0]       ram_raddr;
  ffra_pkg::mem_word_t ram_wdata;
  ffra_pkg::mem_word_t ram_rdata;

  // capacity register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= ffra_pkg::CAP_RESET;
    end else if (cfg_we) begin
      cap_r <= cfg_wdata;
    end
  end

  // capacity saturates at the table size
  assign eff_cap = (32'(cap_r) > MEM_UNITS) ? ffra_pkg::CAP_W'(MEM_UNITS) : cap_r;

  ffra_ram #(
    .WIDTH ($bits(ffra_pkg::mem_word_t)),
    .DEPTH (MEM_UNITS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  ffra_seq #(
    .MEM_UNITS (MEM_UNITS)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_beat   (in_beat),
    .busy      (busy),
    .out_valid (out_valid),
    .out_beat  (out_beat),
    .eff_cap   (eff_cap),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

endmodule

`default_nettype wire
